[hdl/dring_pkg.sv]
// shared constants and types for the double-ended ring queue
`default_nettype none
package dring_pkg;

	// storage geometry
	localparam int MAX_SLOTS = 64;
	localparam int ITEM_BITS = 32;
	localparam int IDX_BITS  = $clog2(MAX_SLOTS);
	localparam int SZ_BITS   = IDX_BITS + 1;

	// fixed field widths
	localparam int CMD_BITS = 2;
	localparam int CFG_BITS = 7;
	localparam int LEN_BITS = 6;

	// reset value of the ring size register
	localparam logic [CFG_BITS-1:0] RING_SIZE_RST = CFG_BITS'(16);

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_POP        = 2'd2;

	// result of one command as it leaves the control stage
	typedef struct packed {
		logic                 accepted;
		logic [ITEM_BITS-1:0] popped_value;
		logic                 from_fast_slot;
		logic [LEN_BITS-1:0]  ring_length;
		logic                 fast_full;
		logic                 use_mem;
	} dring_res_t;

endpackage
`default_nettype wire

[hdl/dring_if.sv]
// channel interfaces: command beats, result beats and ring size writes
`default_nettype none
interface dring_req_if import dring_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_BITS-1:0]  cmd;
	logic [ITEM_BITS-1:0] item_value;

	modport source (output valid, output cmd, output item_value, input ready);
	modport sink (input valid, input cmd, input item_value, output ready);
endinterface

interface dring_rsp_if import dring_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic [ITEM_BITS-1:0] popped_value;
	logic                 from_fast_slot;
	logic [LEN_BITS-1:0]  ring_length;
	logic                 fast_full;

	modport source (output valid, output accepted, output popped_value,
		output from_fast_slot, output ring_length, output fast_full, input ready);
	modport sink (input valid, input accepted, input popped_value,
		input from_fast_slot, input ring_length, input fast_full, output ready);
endinterface

interface dring_cfg_if import dring_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/double_ended_ring_queue_fast_slot.sv]
// top level of the double-ended work queue with fast slot
//
// req carries one command per beat: push at back, push at front or pop,
// with the item handle. rsp returns exactly one result beat per command, in
// order: accepted, popped value, fast slot use, ring length and fast slot
// occupancy after the command. cfg writes the ring size; a write empties the
// ring and keeps the fast slot. The user issues it only while the queue is
// idle; the block itself does not enforce this. Each result passes the read
// stage and the output register before it is on rsp. The queue takes one
// command per cycle while req.ready is high; ring writes finish at the edge
// that takes the command, so a later read of the same slot sees the new data.
// Reset clears pointers, the fast slot and all beats in flight, and sets the
// ring size to 16; the ring memory itself is not cleared and needs no pass.
// When rsp stalls, one result waits in the output register and one in the
// read stage; req.ready drops only when both are full.
`default_nettype none
module double_ended_ring_queue_fast_slot import dring_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	dring_req_if.sink   req,
	dring_rsp_if.source rsp,
	dring_cfg_if.sink   cfg
);

	logic                 stage_ready;
	logic                 res_valid;
	dring_res_t           res;
	logic                 mem_we;
	logic [IDX_BITS-1:0]  mem_waddr;
	logic [ITEM_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [IDX_BITS-1:0]  mem_raddr;
	logic [ITEM_BITS-1:0] mem_rdata;

	// command control
	dring_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg         (cfg),
		.stage_ready (stage_ready),
		.res_valid   (res_valid),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	// ring storage
	dring_ram #(
		.DEPTH (MAX_SLOTS),
		.WIDTH (ITEM_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result path
	dring_resp u_resp (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.mem_rdata   (mem_rdata),
		.stage_ready (stage_ready),
		.rsp         (rsp)
	);

endmodule
`default_nettype wire

[hdl/dring_ram.sv]
// simple dual-port ram, one write and one registered read port
`default_nettype none
module dring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/dring_ctrl.sv]
// pointer, fast slot and ring size control, issues ring reads and writes
`default_nettype none
module dring_ctrl import dring_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dring_req_if.sink                 req,
	dring_cfg_if.sink                 cfg,
	input  wire logic                 stage_ready,
	output logic                      res_valid,
	output dring_res_t                res,
	output logic                      mem_we,
	output logic      [IDX_BITS-1:0]  mem_waddr,
	output logic      [ITEM_BITS-1:0] mem_wdata,
	output logic                      mem_re,
	output logic      [IDX_BITS-1:0]  mem_raddr
);

	logic [CFG_BITS-1:0]  ring_size_q;
	logic [IDX_BITS-1:0]  head_q;
	logic [IDX_BITS-1:0]  tail_q;
	logic [ITEM_BITS-1:0] fast_entry_q;
	logic                 fast_valid_q;

	logic [SZ_BITS-1:0]   sz;
	logic [IDX_BITS-1:0]  hi;
	logic [IDX_BITS-1:0]  ti;
	logic [SZ_BITS-1:0]   len_cur;
	logic [SZ_BITS-1:0]   len_new;
	logic [IDX_BITS-1:0]  head_nxt;
	logic [IDX_BITS-1:0]  tail_nxt;
	logic [IDX_BITS-1:0]  head_inc;
	logic [IDX_BITS-1:0]  tail_inc;
	logic [IDX_BITS-1:0]  tail_dec;
	logic                 fast_valid_nxt;
	logic [ITEM_BITS-1:0] fast_entry_nxt;
	logic                 beat;

	assign req.ready = stage_ready;
	assign cfg.ready = 1'b1;
	assign beat      = req.valid && stage_ready;
	assign res_valid = beat;

	// ring size in use, clamped to the legal range
	always_comb begin
		if (ring_size_q < CFG_BITS'(2)) begin
			sz = SZ_BITS'(2);
		end else if (32'(ring_size_q) > MAX_SLOTS) begin
			sz = SZ_BITS'(MAX_SLOTS);
		end else begin
			sz = SZ_BITS'(ring_size_q);
		end
	end

	// pointers folded back into range
	assign hi = ({1'b0, head_q} >= sz) ? '0 : head_q;
	assign ti = ({1'b0, tail_q} >= sz) ? '0 : tail_q;

	// wrapped neighbors of the pointers
	assign head_inc = ({1'b0, hi} + SZ_BITS'(1) >= sz) ? '0 : hi + IDX_BITS'(1);
	assign tail_inc = ({1'b0, ti} + SZ_BITS'(1) >= sz) ? '0 : ti + IDX_BITS'(1);
	assign tail_dec = (ti == '0) ? IDX_BITS'(sz - SZ_BITS'(1)) : ti - IDX_BITS'(1);

	// occupied ring entries before the command
	assign len_cur = (hi < ti) ? {1'b0, hi} + sz - {1'b0, ti} : {1'b0, hi} - {1'b0, ti};

	// command decode and next state
	always_comb begin
		head_nxt          = hi;
		tail_nxt          = ti;
		fast_valid_nxt    = fast_valid_q;
		fast_entry_nxt    = fast_entry_q;
		mem_we            = 1'b0;
		mem_waddr         = hi;
		mem_wdata         = req.item_value;
		mem_re            = 1'b0;
		mem_raddr         = ti;
		res.accepted       = 1'b0;
		res.popped_value   = '0;
		res.from_fast_slot = 1'b0;
		res.use_mem        = 1'b0;
		unique case (req.cmd) inside
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (!fast_valid_q) begin
					fast_valid_nxt     = 1'b1;
					fast_entry_nxt     = req.item_value;
					res.accepted       = 1'b1;
					res.from_fast_slot = 1'b1;
				end else if (len_cur < sz - SZ_BITS'(1)) begin
					res.accepted = 1'b1;
					mem_we       = beat;
					if (req.cmd == CMD_PUSH_BACK) begin
						mem_waddr = hi;
						head_nxt  = head_inc;
					end else begin
						mem_waddr = tail_dec;
						tail_nxt  = tail_dec;
					end
				end
			end
			CMD_POP: begin
				if (fast_valid_q) begin
					res.popped_value   = fast_entry_q;
					res.accepted       = 1'b1;
					res.from_fast_slot = 1'b1;
					fast_valid_nxt     = 1'b0;
					fast_entry_nxt     = '0;
				end else if (hi != ti) begin
					mem_re       = beat;
					tail_nxt     = tail_inc;
					res.accepted = 1'b1;
					res.use_mem  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.fast_full = fast_valid_nxt;
		res.ring_length = LEN_BITS'(len_new);
	end

	// occupied ring entries after the command
	assign len_new = (head_nxt < tail_nxt) ?
		{1'b0, head_nxt} + sz - {1'b0, tail_nxt} : {1'b0, head_nxt} - {1'b0, tail_nxt};

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q  <= RING_SIZE_RST;
			head_q       <= '0;
			tail_q       <= '0;
			fast_entry_q <= '0;
			fast_valid_q <= 1'b0;
		end else if (cfg.valid) begin
			ring_size_q <= cfg.data;
			head_q      <= '0;
			tail_q      <= '0;
		end else if (beat) begin
			head_q       <= head_nxt;
			tail_q       <= tail_nxt;
			fast_entry_q <= fast_entry_nxt;
			fast_valid_q <= fast_valid_nxt;
		end
	end

endmodule
`default_nettype wire

[hdl/dring_resp.sv]
// read-data stage and output register for result beats
`default_nettype none
module dring_resp import dring_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_valid,
	input  wire dring_res_t           res,
	input  wire logic [ITEM_BITS-1:0] mem_rdata,
	output logic                      stage_ready,
	dring_rsp_if.source               rsp
);

	logic       valid_s1;
	dring_res_t res_s1;
	logic       out_valid_q;
	logic       advance;

	assign advance     = valid_s1 && (!out_valid_q || rsp.ready);
	assign stage_ready = !valid_s1 || advance;
	assign rsp.valid   = out_valid_q;

	// stage waiting for the ring read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stage_ready) begin
			valid_s1 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready && res_valid) begin
			res_s1 <= res;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, ring data merged in here
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.accepted       <= res_s1.accepted;
			rsp.popped_value   <= res_s1.use_mem ? mem_rdata : res_s1.popped_value;
			rsp.from_fast_slot <= res_s1.from_fast_slot;
			rsp.ring_length    <= res_s1.ring_length;
			rsp.fast_full      <= res_s1.fast_full;
		end
	end

endmodule
`default_nettype wire

[hdl/dring_chk.sv]
// port-level checks on result beats, bound to the top level
`default_nettype none
module dring_chk import dring_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic                 accepted,
	input wire logic [ITEM_BITS-1:0] popped_value,
	input wire logic                 from_fast_slot,
	input wire logic                 fast_full
);

	// a stalled result beat stays valid and holds its accepted flag, value, fast slot use and fast slot occupancy
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted)
			&& $stable(popped_value) && $stable(from_fast_slot) && $stable(fast_full))
		else $error("result beat changed while stalled");

	// a refused command returns no value and no fast slot use
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !accepted |-> popped_value == '0 && !from_fast_slot)
		else $error("refused command shows value or fast slot use");

	// a nonzero value taken from the fast slot leaves it empty
	a_fast_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && accepted && from_fast_slot && popped_value != '0 |-> !fast_full)
		else $error("fast slot still full after popping it");

endmodule

bind double_ended_ring_queue_fast_slot dring_chk u_dring_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.accepted       (rsp.accepted),
	.popped_value   (rsp.popped_value),
	.from_fast_slot (rsp.from_fast_slot),
	.fast_full      (rsp.fast_full)
);
`default_nettype wire
